// ===== rtl/core/brl_pkg.sv =====
package brl_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam int ORIGIN_BITS = 12;
    localparam int SCALE_BITS  = 16;
    localparam int FRAME_BITS  = 13;
    localparam int COLOR_BITS  = 24;
    localparam int PIXEL_BITS  = 12;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_X      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_Y      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRAW_COLOR   = 3'd6;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [ORIGIN_BITS-1:0] ORIGIN_RESET       = 12'd0;
    localparam logic [SCALE_BITS-1:0]  SCALE_RESET        = 16'd256;
    localparam logic [FRAME_BITS-1:0]  FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [FRAME_BITS-1:0]  FRAME_HEIGHT_RESET = 13'd480;
    localparam logic [COLOR_BITS-1:0]  COLOR_RESET        = 24'h00FF00;

endpackage

// ===== rtl/core/bresenham_line_rasterizer.sv =====
// An accepted step beat's pixel passes the s1 and s2 registers into the result register.
// One beat per cycle unless stalled; a load or a step with no active line yields no result.
// The stages are: walk state update, scale multiply, origin add with clip compare.
// Each stage advances on its own, so bubbles close up while the output is stalled.
// Reset clears the walk state and valid flags and restores the config registers' reset values.
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [brl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [brl_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic signed [COORD_BITS-1:0]         start_x,
    input  logic signed [COORD_BITS-1:0]         start_y,
    input  logic signed [COORD_BITS-1:0]         end_x,
    input  logic signed [COORD_BITS-1:0]         end_y,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [brl_pkg::PIXEL_BITS-1:0]       pixel_x,
    output logic [brl_pkg::PIXEL_BITS-1:0]       pixel_y,
    output logic [brl_pkg::COLOR_BITS-1:0]       pixel_color,
    output logic                                 visible,
    output logic                                 last
);

    localparam int CB = COORD_BITS;
    localparam int EW = CB + 3;
    localparam int IW = CB + 2;
    localparam int PW = CB + brl_pkg::SCALE_BITS;
    localparam int SW = PW + 1;
    localparam int QW = SW - 9;

    logic [brl_pkg::ORIGIN_BITS-1:0]        origin_x_reg;
    logic [brl_pkg::ORIGIN_BITS-1:0]        origin_y_reg;
    logic signed [brl_pkg::SCALE_BITS-1:0]  scale_x_reg;
    logic signed [brl_pkg::SCALE_BITS-1:0]  scale_y_reg;
    logic [brl_pkg::FRAME_BITS-1:0]         frame_width_reg;
    logic [brl_pkg::FRAME_BITS-1:0]         frame_height_reg;
    logic [brl_pkg::COLOR_BITS-1:0]         draw_color_reg;

    logic                   line_active_reg, line_active_next;
    logic                   steep_flag_reg, steep_flag_next;
    logic                   minor_down_reg, minor_down_next;
    logic signed [CB-1:0]   major_pos_reg, major_pos_next;
    logic signed [CB-1:0]   minor_pos_reg, minor_pos_next;
    logic signed [CB-1:0]   major_end_reg, major_end_next;
    logic signed [EW-1:0]   error_term_reg, error_term_next;
    logic [IW-1:0]          straight_inc_reg, straight_inc_next;
    logic signed [IW-1:0]   diagonal_inc_reg, diagonal_inc_next;

    logic                   s1_valid_reg;
    logic signed [CB-1:0]   s1_ux_reg;
    logic signed [CB-1:0]   s1_uy_reg;
    logic                   s1_last_reg;

    logic                   s2_valid_reg;
    logic signed [PW-1:0]   s2_prod_x_reg;
    logic signed [PW-1:0]   s2_prod_y_reg;
    logic                   s2_last_reg;

    logic                   en_out, en2, en1;
    logic                   in_beat, step_beat, emit;
    logic                   at_end;

    logic signed [CB:0]     ddx, ddy;
    logic [CB:0]            adx, ady;
    logic                   steep, swap;
    logic signed [CB-1:0]   ma1, ma2, mi1, mi2;
    logic signed [CB-1:0]   maj_start, maj_stop, min_start, min_stop;
    logic signed [CB:0]     run, rise;
    logic [CB:0]            rise_abs;

    logic signed [SW-1:0]   sum_x, sum_y;
    logic [QW-1:0]          qx, qy;
    logic                   vis_x, vis_y, vis;

    assign cfg_ready = 1'b1;

    assign en_out   = !out_valid || out_ready;
    assign en2      = !s2_valid_reg || en_out;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    assign in_beat   = in_valid && in_ready;
    assign step_beat = in_beat && (command == brl_pkg::CMD_STEP);
    assign at_end    = (major_pos_reg == major_end_reg);
    assign emit      = step_beat && line_active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= brl_pkg::ORIGIN_RESET;
            origin_y_reg     <= brl_pkg::ORIGIN_RESET;
            scale_x_reg      <= brl_pkg::SCALE_RESET;
            scale_y_reg      <= brl_pkg::SCALE_RESET;
            frame_width_reg  <= brl_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= brl_pkg::FRAME_HEIGHT_RESET;
            draw_color_reg   <= brl_pkg::COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                brl_pkg::REG_ORIGIN_X:
                    origin_x_reg <= cfg_data[brl_pkg::ORIGIN_BITS-1:0];
                brl_pkg::REG_ORIGIN_Y:
                    origin_y_reg <= cfg_data[brl_pkg::ORIGIN_BITS-1:0];
                brl_pkg::REG_SCALE_X:
                    scale_x_reg <= cfg_data[brl_pkg::SCALE_BITS-1:0];
                brl_pkg::REG_SCALE_Y:
                    scale_y_reg <= cfg_data[brl_pkg::SCALE_BITS-1:0];
                brl_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[brl_pkg::FRAME_BITS-1:0];
                brl_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[brl_pkg::FRAME_BITS-1:0];
                brl_pkg::REG_DRAW_COLOR:
                    draw_color_reg <= cfg_data[brl_pkg::COLOR_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Line setup: swap axes for a steep line, then order along the major axis.
    always_comb
    begin
        ddx      = {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
        ddy      = {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
        adx      = ddx[CB] ? -ddx : ddx;
        ady      = ddy[CB] ? -ddy : ddy;
        steep    = ady > adx;
        ma1      = steep ? start_y : start_x;
        mi1      = steep ? start_x : start_y;
        ma2      = steep ? end_y : end_x;
        mi2      = steep ? end_x : end_y;
        swap     = ma1 > ma2;
        maj_start = swap ? ma2 : ma1;
        maj_stop  = swap ? ma1 : ma2;
        min_start = swap ? mi2 : mi1;
        min_stop  = swap ? mi1 : mi2;
        run      = {maj_stop[CB-1], maj_stop} - {maj_start[CB-1], maj_start};
        rise     = {min_stop[CB-1], min_stop} - {min_start[CB-1], min_start};
        rise_abs = rise[CB] ? -rise : rise;
    end

    always_comb
    begin
        line_active_next  = line_active_reg;
        steep_flag_next   = steep_flag_reg;
        minor_down_next   = minor_down_reg;
        major_pos_next    = major_pos_reg;
        minor_pos_next    = minor_pos_reg;
        major_end_next    = major_end_reg;
        error_term_next   = error_term_reg;
        straight_inc_next = straight_inc_reg;
        diagonal_inc_next = diagonal_inc_reg;
        if (in_beat && (command == brl_pkg::CMD_LOAD))
        begin
            line_active_next  = 1'b1;
            steep_flag_next   = steep;
            minor_down_next   = !(min_start < min_stop);
            major_pos_next    = maj_start;
            minor_pos_next    = min_start;
            major_end_next    = maj_stop;
            straight_inc_next = {rise_abs, 1'b0};
            diagonal_inc_next = {rise_abs, 1'b0} - {run, 1'b0};
            error_term_next   = $signed({2'b00, rise_abs}) - $signed({run[CB], run[CB], run});
            error_term_next   = error_term_next + $signed({2'b00, rise_abs});
        end
        else if (emit)
        begin
            if (at_end)
            begin
                line_active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + 1'b1;
                if (error_term_reg[EW-1])
                begin
                    error_term_next = error_term_reg + $signed({1'b0, straight_inc_reg});
                end
                else
                begin
                    error_term_next = error_term_reg
                                    + {diagonal_inc_reg[IW-1], diagonal_inc_reg};
                    minor_pos_next  = minor_down_reg ? minor_pos_reg - 1'b1
                                                     : minor_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg  <= 1'b0;
            steep_flag_reg   <= 1'b0;
            minor_down_reg   <= 1'b0;
            major_pos_reg    <= '0;
            minor_pos_reg    <= '0;
            major_end_reg    <= '0;
            error_term_reg   <= '0;
            straight_inc_reg <= '0;
            diagonal_inc_reg <= '0;
        end
        else
        begin
            line_active_reg  <= line_active_next;
            steep_flag_reg   <= steep_flag_next;
            minor_down_reg   <= minor_down_next;
            major_pos_reg    <= major_pos_next;
            minor_pos_reg    <= minor_pos_next;
            major_end_reg    <= major_end_next;
            error_term_reg   <= error_term_next;
            straight_inc_reg <= straight_inc_next;
            diagonal_inc_reg <= diagonal_inc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= emit;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_ux_reg   <= steep_flag_reg ? minor_pos_reg : major_pos_reg;
            s1_uy_reg   <= steep_flag_reg ? major_pos_reg : minor_pos_reg;
            s1_last_reg <= at_end;
        end
        if (en2)
        begin
            s2_prod_x_reg <= s1_ux_reg * scale_x_reg;
            s2_prod_y_reg <= s1_uy_reg * scale_y_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // The quotient by 256 truncates toward zero, so a small negative sum still maps to zero.
    always_comb
    begin
        sum_x = $signed({{(SW-brl_pkg::ORIGIN_BITS-8){1'b0}}, origin_x_reg, 8'd0})
              + {s2_prod_x_reg[PW-1], s2_prod_x_reg};
        sum_y = $signed({{(SW-brl_pkg::ORIGIN_BITS-8){1'b0}}, origin_y_reg, 8'd0})
              + {s2_prod_y_reg[PW-1], s2_prod_y_reg};
        qx    = sum_x[SW-1] ? '0 : sum_x[SW-2:8];
        qy    = sum_y[SW-1] ? '0 : sum_y[SW-2:8];
        vis_x = (sum_x[SW-1] ? ((&sum_x[SW-1:8]) && (|sum_x[7:0])) : 1'b1)
              && (qx < {{(QW-brl_pkg::FRAME_BITS){1'b0}}, frame_width_reg});
        vis_y = (sum_y[SW-1] ? ((&sum_y[SW-1:8]) && (|sum_y[7:0])) : 1'b1)
              && (qy < {{(QW-brl_pkg::FRAME_BITS){1'b0}}, frame_height_reg});
        vis   = vis_x && vis_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            pixel_x     <= vis ? qx[brl_pkg::PIXEL_BITS-1:0] : '0;
            pixel_y     <= vis ? qy[brl_pkg::PIXEL_BITS-1:0] : '0;
            pixel_color <= draw_color_reg;
            visible     <= vis;
            last        <= s2_last_reg;
        end
    end

    a_hidden_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> (pixel_x == '0) && (pixel_y == '0))
        else $error("hidden pixel carries nonzero coordinates");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        emit && at_end |=> !line_active_reg)
        else $error("line still active after its last pixel");

    a_walk_advances: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !at_end |=> line_active_reg && (major_pos_reg == $past(major_pos_reg) + 1'b1))
        else $error("major position did not advance by one");

    a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step_beat && !line_active_reg |=> !s1_valid_reg)
        else $error("step without a line produced a pixel");

endmodule
